FILE: hw/rtl/rif_pkg.sv
// Shared types and constants of the recursive IIR filter.
package rif_pkg;

  localparam int DATA_W      = 32;
  localparam int COEF_W      = 18;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_B_REGS  = 3;
  localparam int NUM_A_REGS  = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [COEF_W-1:0] COEF_ONE   = 18'sd65536;
  localparam logic signed [DATA_W-1:0] DATA_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN   = 32'sh8000_0000;
  localparam logic [FRAC_W-1:0]        ROUND_HALF = 16'h8000;

  typedef enum logic {
    KIND_FEED = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0     = 3'd0,
    REG_COEF_B1     = 3'd1,
    REG_COEF_B2     = 3'd2,
    REG_COEF_A1     = 3'd3,
    REG_COEF_A2     = 3'd4,
    REG_INIT_INPUT  = 3'd5,
    REG_INIT_OUTPUT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                     is_step;
    logic signed [DATA_W-1:0] sample;
  } item_t;

endpackage

FILE: hw/rtl/rif_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module rif_front import rif_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,  // [31:0] sample
  input  logic              in_tuser,  // [0] kind
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;
  item_t            new_item;

  assign in_tready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    new_item.is_step = (in_tuser == KIND_STEP);
    new_item.sample  = in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

FILE: hw/rtl/rif_back.sv
// Back end: coefficient registers, filter histories, product stage and output register.
module rif_back import rif_pkg::*; #(
  parameter int NUM_INPUT_TAPS = 3,
  parameter int FEEDBACK_ORDER = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_ready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata
);

  localparam int NB     = (NUM_INPUT_TAPS < NUM_B_REGS) ? NUM_INPUT_TAPS : NUM_B_REGS;
  localparam int NA     = (FEEDBACK_ORDER < NUM_A_REGS) ? FEEDBACK_ORDER : NUM_A_REGS;
  localparam int NP     = NB + NA;
  localparam int NY     = FEEDBACK_ORDER + 1;
  localparam int OPC_W  = COEF_W + 1;
  localparam int PROD_W = OPC_W + DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(NP) + 1;

  logic signed [COEF_W-1:0] coef_b_r [NUM_B_REGS];
  logic signed [COEF_W-1:0] coef_a_r [NUM_A_REGS];
  logic signed [DATA_W-1:0] init_in_r;
  logic signed [DATA_W-1:0] init_out_r;

  logic signed [DATA_W-1:0] x_r [NUM_INPUT_TAPS];
  logic signed [DATA_W-1:0] y_r [NY];
  logic signed [DATA_W-1:0] x_eff [NUM_INPUT_TAPS];
  logic signed [DATA_W-1:0] y_eff [NY];
  logic                     primed_r;

  logic signed [OPC_W-1:0]  op_c [NP];
  logic signed [DATA_W-1:0] op_d [NP];
  logic signed [PROD_W-1:0] prod_r [NP];
  logic                     p_valid_r, p_valid_nxt;
  logic                     p_step_r;

  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r;

  logic                     hazard, p_move, p_free, issue;
  logic signed [DATA_W:0]   feed_sum;
  logic signed [DATA_W-1:0] feed_sat;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  acc_shifted;
  logic signed [DATA_W-1:0] y_new;

  // A step needs the newest output of a step still in the product stage.
  assign hazard  = q_item.is_step && p_valid_r && p_step_r;
  assign p_move  = p_valid_r && (!out_valid_r || out_tready);
  assign p_free  = !p_valid_r || p_move;
  assign issue   = q_valid && p_free && !hazard;
  assign q_ready = issue;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b_r[0] <= COEF_ONE;
      coef_b_r[1] <= '0;
      coef_b_r[2] <= '0;
      coef_a_r[0] <= '0;
      coef_a_r[1] <= '0;
      init_in_r   <= '0;
      init_out_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_B0:     coef_b_r[0] <= cfg_data[COEF_W-1:0];
        REG_COEF_B1:     coef_b_r[1] <= cfg_data[COEF_W-1:0];
        REG_COEF_B2:     coef_b_r[2] <= cfg_data[COEF_W-1:0];
        REG_COEF_A1:     coef_a_r[0] <= cfg_data[COEF_W-1:0];
        REG_COEF_A2:     coef_a_r[1] <= cfg_data[COEF_W-1:0];
        REG_INIT_INPUT:  init_in_r   <= cfg_data;
        REG_INIT_OUTPUT: init_out_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_INPUT_TAPS; i++) begin
      if (primed_r) begin
        x_eff[i] = x_r[i];
      end else begin
        x_eff[i] = (i == 0) ? '0 : init_in_r;
      end
    end
    for (int i = 0; i < NY; i++) begin
      y_eff[i] = primed_r ? y_r[i] : init_out_r;
    end
  end

  // Feedback terms are negated here so that the sum stage only adds.
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      op_c[i] = OPC_W'(coef_b_r[i]);
      op_d[i] = x_eff[i];
    end
    for (int k = 0; k < NA; k++) begin
      op_c[NB + k] = -OPC_W'(coef_a_r[k]);
      op_d[NB + k] = y_eff[k];
    end
  end

  always_comb begin
    feed_sum = (DATA_W + 1)'(x_eff[0]) + (DATA_W + 1)'(q_item.sample);
    if (feed_sum[DATA_W] != feed_sum[DATA_W-1]) begin
      feed_sat = feed_sum[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      feed_sat = feed_sum[DATA_W-1:0];
    end
  end

  always_comb begin
    acc_sum = ACC_W'({1'b0, ROUND_HALF});
    for (int i = 0; i < NP; i++) begin
      acc_sum = acc_sum + ACC_W'(prod_r[i]);
    end
    acc_shifted = acc_sum >>> FRAC_W;
    if (acc_shifted > ACC_W'(DATA_MAX)) begin
      y_new = DATA_MAX;
    end else if (acc_shifted < ACC_W'(DATA_MIN)) begin
      y_new = DATA_MIN;
    end else begin
      y_new = acc_shifted[DATA_W-1:0];
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (issue) begin
      p_valid_nxt = 1'b1;
    end else if (p_move) begin
      p_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && !out_tready;
    if (p_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      primed_r    <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (issue) begin
        primed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_step_r <= q_item.is_step;
      for (int i = 0; i < NP; i++) begin
        prod_r[i] <= PROD_W'(op_c[i]) * PROD_W'(op_d[i]);
      end
      if (q_item.is_step) begin
        x_r[0] <= '0;
        for (int i = 1; i < NUM_INPUT_TAPS; i++) begin
          x_r[i] <= x_eff[i-1];
        end
      end else begin
        x_r[0] <= feed_sat;
        for (int i = 1; i < NUM_INPUT_TAPS; i++) begin
          x_r[i] <= x_eff[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue && !primed_r) begin
      for (int i = 0; i < NY; i++) begin
        y_r[i] <= init_out_r;
      end
    end else if (p_move && p_step_r) begin
      y_r[0] <= y_new;
      for (int i = 1; i < NY; i++) begin
        y_r[i] <= y_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_data_r <= p_step_r ? y_new : y_r[0];
    end
  end

endmodule

FILE: hw/rtl/recursive_iir_filter.sv
// Top level of the direct-form-I recursive filter in Q16.16 fixed point.
//
//   Channel | Direction | Handshake         | Payload
//   in_     | input     | in_tvalid/tready  | tdata: sample, tuser: kind
//   out_    | output    | out_tvalid/tready | tdata: newest_output
//   cfg_    | input     | cfg_wr_en         | cfg_index, cfg_data
//
// A feed passes the product stage and the output register; feeds stream at one per cycle
// while the output does not stall. A step is multiplied into the product stage and summed
// into the output register; the feedback through the newest output means a step directly
// behind another step issues only once that step has left the product stage.
// Reset is synchronous; the two-entry queue absorbs two transactions while the output stalls.
module recursive_iir_filter import rif_pkg::*; #(
  parameter int NUM_INPUT_TAPS = 3,
  parameter int FEEDBACK_ORDER = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] sample
  input  logic                 in_tuser,   // [0] kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [31:0] newest_output
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  rif_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  rif_back #(
    .NUM_INPUT_TAPS (NUM_INPUT_TAPS),
    .FEEDBACK_ORDER (FEEDBACK_ORDER)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hw/rtl/rif_checker.sv
// Port-level checker of the recursive IIR filter and its bind to the top level.
module rif_checker import rif_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [DATA_W-1:0]    out_tdata
);

  localparam int CAPACITY = QUEUE_DEPTH + 2;
  localparam int PEND_W   = $clog2(CAPACITY + 1);

  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic              in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != '0)
    else $error("result shown without an outstanding transaction");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(CAPACITY))
    else $error("more transactions in flight than the block can hold");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == '0 |-> in_tready)
    else $error("input not ready while the block is empty");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind recursive_iir_filter rif_checker u_rif_checker (.*);
